// File: rtl/centered_window_average_macros.svh
// Assertion macros for the centered window average block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef CENTERED_WINDOW_AVERAGE_MACROS_SVH
`define CENTERED_WINDOW_AVERAGE_MACROS_SVH
`ifndef SYNTHESIS
`define CWA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CWA_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define CWA_ASSERT(lbl, clk, rstn, prop, msg)
`define CWA_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// File: rtl/cwa_pkg.sv
// Shared types and constants for the centered window average block.
// No dependencies; imported by cwa_div and centered_window_average.
package cwa_pkg;

  localparam int unsigned RADIUS_W = 6;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SUM   = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/cwa_ring.sv
// Sample ring memory: one write port, one registered read port.
// Read and write at the same address in one cycle return the old entry.
module cwa_ring #(
  parameter int unsigned DEPTH  = 127,
  parameter int unsigned DATA_W = 16
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [DATA_W-1:0]          wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [DATA_W-1:0]          rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/cwa_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on cwa_pkg for the status struct.
module cwa_div #(
  parameter int unsigned DVD_W = 23,
  parameter int unsigned DVS_W = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DVD_W-1:0]        dividend_i,
  input  logic [DVS_W-1:0]        divisor_i,
  output logic [DVD_W-1:0]        quotient_o,
  output cwa_pkg::div_stat_t      stat_o
);
  import cwa_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   trial;
  logic             ge;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// File: rtl/centered_window_average.sv
// Centered window average: top level with sequencer, running sum and output register.
// Depends on cwa_pkg, cwa_ring, cwa_div and centered_window_average_macros.svh.
//
// An item is taken only while the block is idle. It first writes the ring and
// reads the sample that leaves the window, then updates the running sum, then,
// when the window is full, waits on the bit-serial divider and picks up its
// quotient, and last hands the result to the output register. The next item is
// not taken until the block is idle again. Items whose window is not yet full
// skip the divider and give an edge result or none; a last item then flushes the
// remaining edge results. Output stalls hold the result and stretch these steps.
// Results trail the input by radius items; edge positions read all ones (-1).
`include "centered_window_average_macros.svh"
module centered_window_average #(
  parameter int unsigned MAX_RADIUS  = 63,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cwa_pkg::RADIUS_W-1:0]     cfg_radius_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [SAMPLE_BITS-1:0]           sample_i,
  input  logic                             is_last_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [SAMPLE_BITS:0]      average_o,
  output logic                             end_of_run_o
);
  import cwa_pkg::*;

  localparam int unsigned DEPTH = 2 * MAX_RADIUS + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned KW    = $clog2(MAX_RADIUS + 1);
  localparam int unsigned WW    = KW + 1;
  localparam int unsigned CW    = KW + 2;
  localparam int unsigned SUM_W = SAMPLE_BITS + KW + 1;

  state_e                 state_q, state_d;
  logic [KW-1:0]          k_q, k_d;
  logic [AW-1:0]          ptr_q, ptr_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic                   out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0] x_q, x_d;
  logic                   last_q, last_d;
  logic [CW-1:0]          p_q, p_d;
  logic [KW-1:0]          flush_q, flush_d;
  logic [SAMPLE_BITS:0]   avg_q, avg_d;
  logic [SAMPLE_BITS:0]   oavg_q, oavg_d;
  logic                   oend_q, oend_d;

  logic                   in_acc;
  logic                   out_free;
  logic [KW-1:0]          k_clamp;
  logic [WW-1:0]          win;
  logic [AW:0]            ptr_x, win_x;
  logic [AW-1:0]          old_addr;
  logic [AW-1:0]          ptr_next;
  logic [CW-1:0]          cnt_sat;
  logic                   ring_we;
  logic [SAMPLE_BITS-1:0] ring_rdata;
  logic                   p_ge_k, p_ge_2k, p_ge_w;
  logic [SUM_W-1:0]       sub_val, sum_new;
  logic                   div_start;
  logic [SUM_W-1:0]       quotient;
  div_stat_t              div_stat;

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE) | cfg_valid_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;

  assign k_clamp  = (cfg_radius_i > RADIUS_W'(MAX_RADIUS)) ? KW'(MAX_RADIUS)
                                                           : KW'(cfg_radius_i);
  assign win      = {k_q, 1'b1};
  assign ptr_x    = {1'b0, ptr_q};
  assign win_x    = (AW + 1)'(win);
  assign old_addr = (ptr_x >= win_x) ? AW'(ptr_x - win_x)
                                     : AW'(ptr_x + (AW + 1)'(DEPTH) - win_x);
  assign ptr_next = (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + AW'(1);
  assign cnt_sat  = (cnt_q == '1) ? cnt_q : cnt_q + CW'(1);

  assign p_ge_k  = p_q >= CW'(k_q);
  assign p_ge_2k = p_q >= CW'({k_q, 1'b0});
  assign p_ge_w  = p_q >= CW'(win);
  assign sub_val = p_ge_w ? SUM_W'(ring_rdata) : '0;
  assign sum_new = sum_q - sub_val + SUM_W'(x_q);

  cwa_ring #(
    .DEPTH  (DEPTH),
    .DATA_W (SAMPLE_BITS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ptr_q),
    .wdata_i (sample_i),
    .re_i    (ring_we),
    .raddr_i (old_addr),
    .rdata_o (ring_rdata)
  );

  cwa_div #(
    .DVD_W (SUM_W),
    .DVS_W (WW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_new),
    .divisor_i  (win),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    x_d         = x_q;
    last_d      = last_q;
    p_d         = p_q;
    flush_d     = flush_q;
    avg_d       = avg_q;
    out_valid_d = out_valid_q & out_stall_i;
    oavg_d      = oavg_q;
    oend_d      = oend_q;
    ring_we     = 1'b0;
    div_start   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          k_d   = k_clamp;
          ptr_d = '0;
          cnt_d = '0;
          sum_d = '0;
        end else if (in_acc) begin
          x_d     = sample_i;
          last_d  = is_last_i;
          p_d     = cnt_q;
          ring_we = 1'b1;
          ptr_d   = is_last_i ? '0 : ptr_next;
          cnt_d   = is_last_i ? '0 : cnt_sat;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_d = last_q ? '0 : sum_new;
        if (!last_q) begin
          flush_d = '0;
        end else if (p_ge_k) begin
          flush_d = k_q;
        end else begin
          flush_d = KW'(p_q + CW'(1));
        end
        if (p_ge_2k) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else if (p_ge_k) begin
          avg_d   = '1;
          state_d = ST_EMIT;
        end else if (last_q) begin
          state_d = ST_FLUSH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          avg_d   = {1'b0, quotient[SAMPLE_BITS-1:0]};
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          oavg_d      = avg_q;
          oend_d      = last_q & (flush_q == '0);
          state_d     = (flush_q != '0) ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          oavg_d      = '1;
          oend_d      = (flush_q == KW'(1));
          flush_d     = flush_q - KW'(1);
          if (flush_q == KW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    last_q  <= last_d;
    p_q     <= p_d;
    flush_q <= flush_d;
    avg_q   <= avg_d;
    oavg_q  <= oavg_d;
    oend_q  <= oend_d;
  end

  assign out_valid_o  = out_valid_q;
  assign average_o    = $signed(oavg_q);
  assign end_of_run_o = oend_q;

  `CWA_ASSERT(a_accept_to_sum, clk_i, rst_ni, in_acc |=> state_q == ST_SUM, "item not summed")
  `CWA_ASSERT(a_div_active, clk_i, rst_ni, state_q == ST_DIV |-> |div_stat, "divider idle")
  `CWA_ASSERT_NEVER(a_flush_empty, clk_i, rst_ni, state_q == ST_FLUSH && flush_q == '0, "empty flush")

endmodule
